>>> hdl/dced_pkg.sv
// ----------------------------------------------------------------------------
// dced_pkg
// shared types, constants and code tables of the coefficient entropy decoder
// ----------------------------------------------------------------------------
package dced_pkg;

  typedef enum logic [1:0] {
    KIND_DC  = 2'd0,
    KIND_AC  = 2'd1,
    KIND_EOB = 2'd2,
    KIND_ERR = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DC    = 2'd1,
    PH_AC    = 2'd2,
    PH_EXTRA = 2'd3
  } phase_e;

  localparam logic [7:0] SymZrl  = 8'hF0;
  localparam logic [7:0] SymEob  = 8'h00;
  localparam logic [3:0] NibMask = 4'hF;

  // result of one code lookup
  typedef struct packed {
    logic       hit;
    logic [7:0] idx;
  } match_t;

  function automatic logic [7:0] dc_count(logic chroma, logic [3:0] l);
    logic [7:0] c;
    c = 8'd0;
    if (!chroma) begin
      case (l)
        4'd1: c = 8'd1;
        4'd2: c = 8'd5;
        4'd3, 4'd4, 4'd5, 4'd6: c = 8'd1;
        4'd7: c = 8'd2;
        default: c = 8'd0;
      endcase
    end else begin
      case (l)
        4'd1: c = 8'd3;
        4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8: c = 8'd1;
        4'd9: c = 8'd2;
        default: c = 8'd0;
      endcase
    end
    return c;
  endfunction

  function automatic logic [7:0] ac_count(logic chroma, logic [3:0] l);
    logic [7:0] c;
    c = 8'd0;
    if (!chroma) begin
      case (l)
        4'd1: c = 8'd2;  4'd2: c = 8'd1;  4'd3: c = 8'd3;  4'd4: c = 8'd3;
        4'd5: c = 8'd2;  4'd6: c = 8'd4;  4'd7: c = 8'd3;  4'd8: c = 8'd5;
        4'd9: c = 8'd5;  4'd10: c = 8'd4; 4'd11: c = 8'd4; 4'd14: c = 8'd1;
        4'd15: c = 8'h7d;
        default: c = 8'd0;
      endcase
    end else begin
      case (l)
        4'd1: c = 8'd2;  4'd2: c = 8'd1;  4'd3: c = 8'd2;  4'd4: c = 8'd4;
        4'd5: c = 8'd4;  4'd6: c = 8'd3;  4'd7: c = 8'd4;  4'd8: c = 8'd7;
        4'd9: c = 8'd5;  4'd10: c = 8'd4; 4'd11: c = 8'd4; 4'd13: c = 8'd1;
        4'd14: c = 8'd2; 4'd15: c = 8'h77;
        default: c = 8'd0;
      endcase
    end
    return c;
  endfunction

  localparam logic [7:0] AcSymsLuma [162] = '{
    8'h01,8'h02,8'h03,8'h00,8'h04,8'h11,8'h05,8'h12,8'h21,8'h31,8'h41,8'h06,8'h13,8'h51,
    8'h61,8'h07,8'h22,8'h71,8'h14,8'h32,8'h81,8'h91,8'ha1,8'h08,8'h23,8'h42,8'hb1,8'hc1,
    8'h15,8'h52,8'hd1,8'hf0,8'h24,8'h33,8'h62,8'h72,8'h82,8'h09,8'h0a,8'h16,8'h17,8'h18,
    8'h19,8'h1a,8'h25,8'h26,8'h27,8'h28,8'h29,8'h2a,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,
    8'h3a,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4a,8'h53,8'h54,8'h55,8'h56,8'h57,
    8'h58,8'h59,8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,8'h75,
    8'h76,8'h77,8'h78,8'h79,8'h7a,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8a,8'h92,
    8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'ha2,8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,
    8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,8'hc2,8'hc3,
    8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,
    8'hd9,8'hda,8'he1,8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf1,8'hf2,
    8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa
  };

  localparam logic [7:0] AcSymsChroma [162] = '{
    8'h00,8'h01,8'h02,8'h03,8'h11,8'h04,8'h05,8'h21,8'h31,8'h06,8'h12,8'h41,8'h51,8'h07,
    8'h61,8'h71,8'h13,8'h22,8'h32,8'h81,8'h08,8'h14,8'h42,8'h91,8'ha1,8'hb1,8'hc1,8'h09,
    8'h23,8'h33,8'h52,8'hf0,8'h15,8'h62,8'h72,8'hd1,8'h0a,8'h16,8'h24,8'h34,8'he1,8'h25,
    8'hf1,8'h17,8'h18,8'h19,8'h1a,8'h26,8'h27,8'h28,8'h29,8'h2a,8'h35,8'h36,8'h37,8'h38,
    8'h39,8'h3a,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4a,8'h53,8'h54,8'h55,8'h56,
    8'h57,8'h58,8'h59,8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,
    8'h75,8'h76,8'h77,8'h78,8'h79,8'h7a,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,
    8'h8a,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'ha2,8'ha3,8'ha4,8'ha5,
    8'ha6,8'ha7,8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,
    8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,
    8'hd7,8'hd8,8'hd9,8'hda,8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf2,
    8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa
  };

  localparam logic [5:0] ScanOrder [64] = '{
    6'd0, 6'd1, 6'd8, 6'd16,6'd9, 6'd2, 6'd3, 6'd10,6'd17,6'd24,6'd32,6'd25,6'd18,6'd11,
    6'd4, 6'd5, 6'd12,6'd19,6'd26,6'd33,6'd40,6'd48,6'd41,6'd34,6'd27,6'd20,6'd13,6'd6,
    6'd7, 6'd14,6'd21,6'd28,6'd35,6'd42,6'd49,6'd56,6'd57,6'd50,6'd43,6'd36,6'd29,6'd22,
    6'd15,6'd23,6'd30,6'd37,6'd44,6'd51,6'd58,6'd59,6'd52,6'd45,6'd38,6'd31,6'd39,6'd46,
    6'd53,6'd60,6'd61,6'd54,6'd47,6'd55,6'd62,6'd63
  };

endpackage

>>> hdl/dced_code_table.sv
// ----------------------------------------------------------------------------
// dced_code_table
// per-length canonical code limits, updated one length per step_i
// ----------------------------------------------------------------------------
module dced_code_table (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  restart_i,
  input  logic                  step_i,
  input  logic                  is_dc_i,
  input  logic                  chroma_i,
  input  logic [4:0]            len_i,
  input  logic [15:0]           code_i,
  output dced_pkg::match_t      match_o
);

  // first code and symbol base at the current length; code length len_i
  logic [16:0] first_q, first_d;
  logic [7:0]  base_q, base_d;
  logic [7:0]  cnt;
  logic [16:0] diff;
  logic [3:0]  lsel;

  assign lsel = len_i[3:0] - 4'd1;
  assign cnt  = is_dc_i ? dced_pkg::dc_count(chroma_i, lsel)
                        : dced_pkg::ac_count(chroma_i, lsel);
  assign diff = {1'b0, code_i} - first_q;

  always_comb begin
    match_o.hit = (len_i != 5'd0) && ({1'b0, code_i} >= first_q)
                  && (diff < {9'd0, cnt});
    match_o.idx = base_q + diff[7:0];
    first_d = ({first_q} + {9'd0, cnt}) << 1;
    base_d  = base_q + cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      base_q  <= '0;
    end else if (restart_i) begin
      first_q <= '0;
      base_q  <= '0;
    end else if (step_i) begin
      first_q <= first_d;
      base_q  <= base_d;
    end
  end

endmodule

>>> hdl/dct_coefficient_entropy_decoder.sv
// ----------------------------------------------------------------------------
// dct_coefficient_entropy_decoder
// bit-serial run/size coefficient decoder for one 8x8 block
// ----------------------------------------------------------------------------
// input channel: a transaction with command_i = 0 starts a block and carries
// the table choice and neighbor dc context; command_i = 1 moves one stream
// bit, msb first. bits outside an active block are dropped.
// output channel: one transaction per dc value, ac coefficient, end of block
// or decode error; last_o marks the final one of a block.
// one input transaction is taken every cycle that in_ready_o is high; each
// result appears in the cycle after its last bit, from a single output
// register. the canonical code search keeps running first-code and base
// registers, so each bit costs one table read, one subtract and compare.
// when the output register holds a result that is not taken, in_ready_o
// drops until it is taken; otherwise in_ready_o stays high.
// reset puts the block idle with an empty output register.
// ----------------------------------------------------------------------------
module dct_coefficient_entropy_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic               stream_bit_i,
  input  logic               chroma_tables_i,
  input  logic               left_present_i,
  input  logic               top_present_i,
  input  logic signed [15:0] left_dc_i,
  input  logic signed [15:0] top_left_dc_i,
  input  logic signed [15:0] top_dc_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic signed [15:0] level_o,
  output logic [5:0]         position_o,
  output logic               last_o
);

  dced_pkg::phase_e phase_q, phase_d;
  logic [15:0] code_q, code_d;
  logic [4:0]  clen_q, clen_d;
  logic [3:0]  xneed_q, xneed_d, xcnt_q, xcnt_d;
  logic [15:0] xval_q, xval_d;
  logic [3:0]  run_q, run_d;
  logic [6:0]  cidx_q, cidx_d;
  logic        chroma_q, chroma_d;
  logic signed [15:0] pred_q, pred_d;

  logic        ov_q, ov_d;
  logic [1:0]  kind_q, kind_d;
  logic [15:0] lvl_q, lvl_d;
  logic [5:0]  pos_q, pos_d;
  logic        last_q, last_d;

  logic accept, restart, step;
  logic [15:0] code_n;
  logic [4:0]  clen_n;
  dced_pkg::match_t m;
  logic [7:0]  sym;

  assign in_ready_o = !ov_q || out_ready_i;
  assign accept = in_valid_i && in_ready_o;
  assign code_n = {code_q[14:0], stream_bit_i};
  assign clen_n = clen_q + 5'd1;

  // table lookup runs on the pending (code_n, clen_n)
  dced_code_table u_tab (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart),
    .step_i    (step),
    .is_dc_i   (phase_q == dced_pkg::PH_DC),
    .chroma_i  (chroma_q),
    .len_i     (clen_n),
    .code_i    (code_n),
    .match_o   (m)
  );

  assign sym = chroma_q ? dced_pkg::AcSymsChroma[m.idx]
                        : dced_pkg::AcSymsLuma[m.idx];

  always_comb begin
    logic [15:0] xv;
    logic [3:0]  xn;
    logic [3:0]  xc;
    logic [3:0]  rn;
    logic        fin;
    logic signed [16:0] lv, sum;
    logic [7:0]  pos;
    logic signed [16:0] dl, dt;
    logic [16:0] at, al;
    restart = 1'b0;
    step    = 1'b0;
    phase_d = phase_q; code_d = code_q; clen_d = clen_q;
    xneed_d = xneed_q; xcnt_d = xcnt_q; xval_d = xval_q;
    run_d = run_q; cidx_d = cidx_q; chroma_d = chroma_q; pred_d = pred_q;
    ov_d = ov_q && !out_ready_i;
    kind_d = kind_q; lvl_d = lvl_q; pos_d = pos_q; last_d = last_q;
    xv = xval_q; xn = xneed_q; xc = xcnt_q; rn = run_q; fin = 1'b0;
    lv = '0; sum = '0; pos = '0;
    dl = '0; dt = '0; at = '0; al = '0;
    if (accept) begin
      if (!command_i) begin
        restart = 1'b1;
        chroma_d = chroma_tables_i;
        dt = 17'(top_dc_i) - 17'(top_left_dc_i);
        dl = 17'(left_dc_i) - 17'(top_left_dc_i);
        at = dt[16] ? 17'(-dt) : 17'(dt);
        al = dl[16] ? 17'(-dl) : 17'(dl);
        if (top_present_i && left_present_i) pred_d = (at <= al) ? left_dc_i : top_dc_i;
        else if (top_present_i) pred_d = top_dc_i;
        else if (left_present_i) pred_d = left_dc_i;
        else pred_d = '0;
        phase_d = dced_pkg::PH_DC;
        code_d = '0; clen_d = '0; xneed_d = '0; xcnt_d = '0; xval_d = '0;
        run_d = '0; cidx_d = '0;
      end else if (phase_q == dced_pkg::PH_EXTRA) begin
        xv = {xval_q[14:0], stream_bit_i};
        xc = xcnt_q + 4'd1;
        xval_d = xv; xcnt_d = xc;
        fin = (xc >= xneed_q);
      end else if (phase_q != dced_pkg::PH_IDLE) begin
        step = 1'b1;
        code_d = code_n; clen_d = clen_n;
        if (!m.hit) begin
          if (clen_n >= 5'd16) begin
            ov_d = 1'b1; kind_d = dced_pkg::KIND_ERR; lvl_d = '0; pos_d = '0;
            last_d = 1'b1; phase_d = dced_pkg::PH_IDLE;
          end
        end else begin
          restart = 1'b1;
          code_d = '0; clen_d = '0; xcnt_d = '0; xval_d = '0; xv = '0;
          if (phase_q == dced_pkg::PH_DC) begin
            xn = m.idx[3:0] & dced_pkg::NibMask; rn = '0;
            xneed_d = xn; run_d = rn;
            if (xn == 4'd0) fin = 1'b1; else phase_d = dced_pkg::PH_EXTRA;
          end else if (sym == dced_pkg::SymEob) begin
            ov_d = 1'b1; kind_d = dced_pkg::KIND_EOB; lvl_d = '0; pos_d = '0;
            last_d = 1'b1; phase_d = dced_pkg::PH_IDLE;
          end else if (sym == dced_pkg::SymZrl) begin
            cidx_d = cidx_q + 7'd16;
            if (cidx_d == 7'd64) begin
              ov_d = 1'b1; kind_d = dced_pkg::KIND_EOB; lvl_d = '0; pos_d = '0;
              last_d = 1'b1; phase_d = dced_pkg::PH_IDLE;
            end else if (cidx_d > 7'd64) begin
              ov_d = 1'b1; kind_d = dced_pkg::KIND_ERR; lvl_d = '0; pos_d = '0;
              last_d = 1'b1; phase_d = dced_pkg::PH_IDLE;
            end
          end else begin
            rn = sym[7:4]; xn = sym[3:0];
            xneed_d = xn; run_d = rn;
            if (xn == 4'd0) fin = 1'b1; else phase_d = dced_pkg::PH_EXTRA;
          end
        end
      end
      if (fin) begin
        if (xn == 4'd0) lv = '0;
        else if ({16'd0, xv} < (32'd1 << (xn - 4'd1)))
          lv = 17'(xv) - 17'((32'd1 << xn) - 32'd1);
        else lv = 17'(xv);
        ov_d = 1'b1;
        if (cidx_q == 7'd0) begin
          sum = 17'(pred_q) + lv;
          if (sum > 17'sd32767) sum = 17'sd32767;
          if (sum < -17'sd32768) sum = -17'sd32768;
          kind_d = dced_pkg::KIND_DC; lvl_d = sum[15:0]; pos_d = '0; last_d = 1'b0;
          cidx_d = 7'd1; phase_d = dced_pkg::PH_AC;
        end else begin
          pos = {1'b0, cidx_q} + {4'd0, rn};
          if (pos >= 8'd64) begin
            kind_d = dced_pkg::KIND_ERR; lvl_d = '0; pos_d = '0; last_d = 1'b1;
            phase_d = dced_pkg::PH_IDLE;
          end else begin
            kind_d = dced_pkg::KIND_AC; lvl_d = lv[15:0];
            pos_d = dced_pkg::ScanOrder[pos[5:0]];
            last_d = (pos == 8'd63);
            cidx_d = pos[6:0] + 7'd1;
            phase_d = (pos == 8'd63) ? dced_pkg::PH_IDLE : dced_pkg::PH_AC;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dced_pkg::PH_IDLE;
      code_q <= '0; clen_q <= '0; xneed_q <= '0; xcnt_q <= '0; xval_q <= '0;
      run_q <= '0; cidx_q <= '0; chroma_q <= 1'b0; pred_q <= '0;
      ov_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      code_q <= code_d; clen_q <= clen_d; xneed_q <= xneed_d; xcnt_q <= xcnt_d;
      xval_q <= xval_d; run_q <= run_d; cidx_q <= cidx_d; chroma_q <= chroma_d;
      pred_q <= pred_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d; lvl_q <= lvl_d; pos_q <= pos_d; last_q <= last_d;
  end

  assign out_valid_o = ov_q;
  assign kind_o      = kind_q;
  assign level_o     = lvl_q;
  assign position_o  = pos_q;
  assign last_o      = last_q;

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && command_i && ov_d && last_d && !(ov_q && !out_ready_i))
      |=> phase_q == dced_pkg::PH_IDLE)
    else $error("block not idle after final result");
  a_no_bits_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == dced_pkg::PH_IDLE && accept && command_i) |=> !ov_q || $stable(ov_q))
    else $error("result from idle bit");
  a_code_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != dced_pkg::PH_IDLE) |-> clen_q <= 5'd15)
    else $error("code length overrun");

endmodule

>>> dv/dct_coefficient_entropy_decoder_tb.sv
// ----------------------------------------------------------------------------
// dct_coefficient_entropy_decoder_tb
// self-checking regression of the bit-serial coefficient decoder
// ----------------------------------------------------------------------------
// blocks are built with a shadow copy of the decoder state so that most of
// them are well formed (dc size, run/size symbols, end of block), mixed with
// invalid codes, run overflow, truncated blocks and bits outside any block.
// a scoreboard class predicts each result from the accepted input
// transactions and checks the output channel field by field. both channels
// idle and stall at random, with a long receiver hold-off and a drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dct_coefficient_entropy_decoder_tb;

  localparam int Limit = 400000;

  typedef struct packed {
    logic               cmd;
    logic               bitv;
    logic               chroma;
    logic               lp;
    logic               tp;
    logic signed [15:0] ldc;
    logic signed [15:0] tldc;
    logic signed [15:0] tdc;
  } stim_t;

  typedef struct packed {
    dced_pkg::kind_e    kind;
    logic signed [15:0] level;
    logic [5:0]         pos;
    logic               last;
  } coef_t;

  localparam int DcCounts [2][16] = '{
    '{0, 1, 5, 1, 1, 1, 1, 2, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 3, 1, 1, 1, 1, 1, 1, 1, 2, 0, 0, 0, 0, 0, 0}
  };
  localparam int AcCounts [2][16] = '{
    '{0, 2, 1, 3, 3, 2, 4, 3, 5, 5, 4, 4, 0, 0, 1, 125},
    '{0, 2, 1, 2, 4, 4, 3, 4, 7, 5, 4, 4, 0, 1, 2, 119}
  };

  function automatic int code_count(bit ac, bit ch, int l);
    return ac ? AcCounts[ch][l-1] : DcCounts[ch][l-1];
  endfunction

  function automatic int ac_symbol(bit ch, int idx);
    return ch ? int'(dced_pkg::AcSymsChroma[idx % 162])
              : int'(dced_pkg::AcSymsLuma[idx % 162]);
  endfunction

  class coef_scoreboard;
    dced_pkg::phase_e phase;
    logic [15:0] shift;
    logic [15:0] xval;
    int          clen, xneed, xcnt, run, cidx, pred;
    bit          chroma;
    coef_t       pending[$];
    int          mism;

    function new();
      phase = dced_pkg::PH_IDLE;
      shift = '0;
      xval = '0;
      clen = 0; xneed = 0; xcnt = 0; run = 0; cidx = 0; pred = 0;
      chroma = 0;
      mism = 0;
    endfunction

    function automatic int lookup(bit ac, int code, int len);
      int first, base, cnt;
      first = 0;
      base = 0;
      for (int l = 1; l <= 16; l++) begin
        cnt = code_count(ac, chroma, l);
        if (l == len) return (code >= first && code - first < cnt) ? base + code - first : -1;
        first = (first + cnt) << 1;
        base += cnt;
      end
      return -1;
    endfunction

    function automatic bit emit(output coef_t r, input dced_pkg::kind_e k, input int lv,
                                input int p, input bit last);
      r.kind = k;
      r.level = lv[15:0];
      r.pos = p[5:0];
      r.last = last;
      if (last) phase = dced_pkg::PH_IDLE;
      return 1;
    endfunction

    function automatic bit finish(output coef_t r);
      int lv, sum, p;
      lv = 0;
      if (xneed != 0) begin
        lv = int'(xval);
        if (lv < (1 << (xneed - 1))) lv = lv - ((1 << xneed) - 1);
      end
      if (cidx == 0) begin
        sum = pred + lv;
        if (sum > 32767) sum = 32767;
        if (sum < -32768) sum = -32768;
        cidx = 1;
        phase = dced_pkg::PH_AC;
        return emit(r, dced_pkg::KIND_DC, sum, 0, 0);
      end
      p = cidx + run;
      if (p >= 64) return emit(r, dced_pkg::KIND_ERR, 0, 0, 1);
      cidx = p + 1;
      phase = dced_pkg::PH_AC;
      return emit(r, dced_pkg::KIND_AC, lv, int'(dced_pkg::ScanOrder[p]), p == 63);
    endfunction

    function automatic bit step(stim_t s, output coef_t r);
      int idx, sym, l, tl, t;
      r = '0;
      if (!s.cmd) begin
        l = s.ldc;
        tl = s.tldc;
        t = s.tdc;
        chroma = s.chroma;
        if (s.tp && s.lp) begin
          if ((t - tl < 0 ? tl - t : t - tl) <= (l - tl < 0 ? tl - l : l - tl)) pred = l;
          else pred = t;
        end else if (s.tp) pred = t;
        else if (s.lp) pred = l;
        else pred = 0;
        phase = dced_pkg::PH_DC;
        shift = '0;
        xval = '0;
        clen = 0; xneed = 0; xcnt = 0; run = 0; cidx = 0;
        return 0;
      end
      if (phase == dced_pkg::PH_IDLE) return 0;
      if (phase == dced_pkg::PH_EXTRA) begin
        xval = {xval[14:0], s.bitv};
        xcnt++;
        if (xcnt >= xneed) return finish(r);
        return 0;
      end
      shift = {shift[14:0], s.bitv};
      clen++;
      idx = lookup(phase == dced_pkg::PH_AC, int'(shift), clen);
      if (idx < 0) begin
        if (clen >= 16) return emit(r, dced_pkg::KIND_ERR, 0, 0, 1);
        return 0;
      end
      shift = '0;
      clen = 0;
      xcnt = 0;
      xval = '0;
      if (phase == dced_pkg::PH_DC) begin
        xneed = idx & 15;
        run = 0;
      end else begin
        sym = ac_symbol(chroma, idx);
        if (sym == int'(dced_pkg::SymEob)) return emit(r, dced_pkg::KIND_EOB, 0, 0, 1);
        if (sym == int'(dced_pkg::SymZrl)) begin
          cidx += 16;
          if (cidx == 64) return emit(r, dced_pkg::KIND_EOB, 0, 0, 1);
          if (cidx > 64) return emit(r, dced_pkg::KIND_ERR, 0, 0, 1);
          return 0;
        end
        run = sym >> 4;
        xneed = sym & 15;
      end
      if (xneed == 0) return finish(r);
      phase = dced_pkg::PH_EXTRA;
      return 0;
    endfunction

    function void note_input(stim_t s);
      coef_t r;
      if (step(s, r)) pending.push_back(r);
    endfunction

    function void check_result(coef_t got);
      coef_t exp_r;
      if (pending.size() == 0) begin
        mism++;
        if (mism <= 10) $display("unexpected result kind=%0d level=%0d pos=%0d last=%0b",
                                 got.kind, got.level, got.pos, got.last);
        return;
      end
      exp_r = pending.pop_front();
      if (got.kind !== exp_r.kind || got.level !== exp_r.level || got.pos !== exp_r.pos ||
          got.last !== exp_r.last) begin
        mism++;
        if (mism <= 10)
          $display("mismatch exp kind=%0d level=%0d pos=%0d last=%0b got %0d %0d %0d %0b",
                   exp_r.kind, exp_r.level, exp_r.pos, exp_r.last,
                   got.kind, got.level, got.pos, got.last);
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               command_i = 1'b0;
  logic               stream_bit_i = 1'b0;
  logic               chroma_tables_i = 1'b0;
  logic               left_present_i = 1'b0;
  logic               top_present_i = 1'b0;
  logic signed [15:0] left_dc_i = '0;
  logic signed [15:0] top_left_dc_i = '0;
  logic signed [15:0] top_dc_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         kind_o;
  logic signed [15:0] level_o;
  logic [5:0]         position_o;
  logic               last_o;

  dct_coefficient_entropy_decoder dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  coef_scoreboard sb = new();
  coef_scoreboard shadow = new();
  stim_t          feed_q[$];
  bit             quiet = 0;
  bit             hold_req = 0;
  int             hold_cnt = 0;
  int             cycles = 0;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > Limit) begin
      $display("dct_coefficient_entropy_decoder regression: fail");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (hold_req && hold_cnt == 0) begin
      hold_req <= 0;
      hold_cnt <= 300;
      out_ready_i <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= quiet || ($urandom_range(0, 99) >= 23);
    end
  end

  always @(posedge clk_i) begin
    coef_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.kind = dced_pkg::kind_e'(kind_o);
      got.level = level_o;
      got.pos = position_o;
      got.last = last_o;
      sb.check_result(got);
    end
  end

  function automatic stim_t rand_stim();
    stim_t s;
    logic [63:0] w;
    w = {$urandom, $urandom};
    s = stim_t'(w[$bits(stim_t)-1:0]);
    return s;
  endfunction

  function automatic logic [15:0] pick_dc();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void push_start(bit ch, bit lp, bit tp, logic [15:0] l, logic [15:0] tl,
                                     logic [15:0] t);
    stim_t s;
    coef_t r;
    s = rand_stim();
    s.cmd = 0; s.chroma = ch; s.lp = lp; s.tp = tp; s.ldc = l; s.tldc = tl; s.tdc = t;
    void'(shadow.step(s, r));
    feed_q.push_back(s);
  endfunction

  function automatic void push_bit(bit b);
    stim_t s;
    coef_t r;
    s = rand_stim();
    s.cmd = 1;
    s.bitv = b;
    void'(shadow.step(s, r));
    feed_q.push_back(s);
  endfunction

  function automatic void push_code(bit ac, int idx);
    int first, base, cnt, code, len;
    first = 0; base = 0; code = 0; len = 1;
    for (int l = 1; l <= 16; l++) begin
      cnt = code_count(ac, shadow.chroma, l);
      if (idx < base + cnt) begin
        code = first + idx - base;
        len = l;
        break;
      end
      first = (first + cnt) << 1;
      base += cnt;
    end
    for (int i = len - 1; i >= 0; i--) push_bit(code[i]);
  endfunction

  function automatic void push_extra(int n, int v);
    for (int i = n - 1; i >= 0; i--) push_bit(v[i]);
  endfunction

  function automatic void push_ac(int sym, int v);
    for (int i = 0; i < 162; i++)
      if (ac_symbol(shadow.chroma, i) == sym) begin
        push_code(1, i);
        break;
      end
    push_extra(sym & 15, v);
  endfunction

  // random symbols until the block closes, or a cut at nsym for broken blocks
  function automatic void push_body(int nsym, bit bad_tail);
    int idx, sym, n;
    n = $urandom_range(0, 11);
    push_code(0, n);
    push_extra(n, $urandom);
    for (int k = 0; k < nsym && shadow.phase != dced_pkg::PH_IDLE; k++) begin
      if ($urandom_range(0, 99) < 10) begin
        push_ac(int'(dced_pkg::SymEob), 0);
      end else begin
        for (int tries = 0; tries < 10; tries++) begin
          idx = $urandom_range(0, 161);
          sym = ac_symbol(shadow.chroma, idx);
          if (sym == int'(dced_pkg::SymZrl) ? shadow.cidx + 16 <= 64
                                            : shadow.cidx + (sym >> 4) <= 63)
            break;
        end
        push_code(1, idx);
        push_extra(sym & 15, $urandom);
      end
    end
    if (bad_tail)
      while (shadow.phase != dced_pkg::PH_IDLE) push_bit(1'b1);
  endfunction

  task automatic send(stim_t s);
    if (!quiet)
      while ($urandom_range(0, 99) < 23) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    in_valid_i <= 1'b1;
    command_i <= s.cmd;
    stream_bit_i <= s.bitv;
    chroma_tables_i <= s.chroma;
    left_present_i <= s.lp;
    top_present_i <= s.tp;
    left_dc_i <= s.ldc;
    top_left_dc_i <= s.tldc;
    top_dc_i <= s.tdc;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(s);
    @(negedge clk_i);
  endtask

  initial begin
    int r;
    // bits with no active block
    push_bit(1); push_bit(0); push_bit(1);
    // dc saturates high, then end of block
    push_start(0, 1, 1, 16'h7fff, 16'h0000, 16'h0000);
    push_code(0, 11); push_extra(11, 2047); push_ac(int'(dced_pkg::SymEob), 0);
    // dc saturates low, zero runs pass the end
    push_start(1, 0, 1, 16'h1234, 16'h0000, 16'h8000);
    push_code(0, 11); push_extra(11, 0);
    push_ac(int'(dced_pkg::SymZrl), 0); push_ac(int'(dced_pkg::SymZrl), 0);
    push_ac(int'(dced_pkg::SymZrl), 0); push_ac(int'(dced_pkg::SymZrl), 0);
    // zero run lands on 64
    push_start(0, 1, 0, 16'hffff, 16'h0000, 16'h0000);
    push_code(0, 0); push_ac(8'he1, 1);
    push_ac(int'(dced_pkg::SymZrl), 0); push_ac(int'(dced_pkg::SymZrl), 0);
    push_ac(int'(dced_pkg::SymZrl), 0);
    // coefficient at the last scan position
    push_start(1, 0, 0, 16'h0000, 16'h0000, 16'h0000);
    push_code(0, 1); push_extra(1, 0);
    push_ac(int'(dced_pkg::SymZrl), 0); push_ac(int'(dced_pkg::SymZrl), 0);
    push_ac(int'(dced_pkg::SymZrl), 0);
    push_ac(8'he1, 0);
    // invalid codes in dc and ac, then a run past the end, then restart mid-block
    push_start(0, 0, 0, 16'h0000, 16'h0000, 16'h0000);
    repeat (16) push_bit(1);
    push_start(1, 1, 1, 16'h8000, 16'h7fff, 16'h8000);
    push_code(0, 2); push_extra(2, 3);
    repeat (16) push_bit(1);
    push_start(0, 0, 0, 16'h0000, 16'h0000, 16'h0000);
    push_code(0, 0); push_ac(int'(dced_pkg::SymZrl), 0); push_ac(int'(dced_pkg::SymZrl), 0);
    push_ac(int'(dced_pkg::SymZrl), 0); push_ac(8'hf1, 1);
    push_start(0, 1, 1, 16'h0010, 16'h0020, 16'h0030);
    push_code(0, 3); push_bit(0);
    push_start(1, 1, 1, 16'h0100, 16'h0020, 16'h0030);
    push_body(64, 0);

    while (feed_q.size() < 700) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 4)) push_bit(1'($urandom));
      end else begin
        push_start(1'($urandom), 1'($urandom), 1'($urandom), pick_dc(), pick_dc(),
                   pick_dc());
        if (r < 78) push_body(64, 0);
        else if (r < 90) push_body($urandom_range(0, 6), 1);
        else push_body($urandom_range(0, 6), 0);
      end
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < feed_q.size(); i++) begin
      quiet = (i >= 120 && i < 280);
      if (i == 350) hold_req = 1;
      if (i == 550) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
        while (sb.pending.size() != 0) @(negedge clk_i);
      end
      send(feed_q[i]);
    end
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (sb.mism == 0 && sb.pending.size() == 0) begin
      $display("dct_coefficient_entropy_decoder regression: pass");
    end else begin
      $display("dct_coefficient_entropy_decoder regression: fail");
    end
    $finish;
  end

endmodule
